### hdl/pulse_and_pwm_byte_signaller_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse and PWM byte signaller
// Concurrent checks sampled on clk and disabled while arst_n is low.
// They compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PULSE_AND_PWM_BYTE_SIGNALLER_TOP_DEFINES_SVH
`define PULSE_AND_PWM_BYTE_SIGNALLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// ante true at a clock edge implies cons at the same edge
`define PPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("pps assertion failed");
// ante true at a clock edge implies cons at the next edge
`define PPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("pps assertion failed");
`else
`define PPS_ASSERT_IMP(lbl, ante, cons)
`define PPS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, widths and constants of the pulse and PWM byte signaller.
// ----------------------------------------------------------------------------
package pps_pkg;

	// field and register widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned IP_W       = 32;
	localparam int unsigned DUTY_W     = 10;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned NUM_BYTES  = 4;
	localparam int unsigned TPM_W      = 20;
	localparam int unsigned PERIOD_W   = 23;
	localparam int unsigned DIGIT_W    = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 23;
	localparam int unsigned STEP_W     = 4;
	localparam int unsigned SEQ_MS_W   = 13;
	localparam int unsigned BTN_MS_W   = 8;

	localparam int unsigned COUNT_WIDTH_DEF = 23;
	localparam int unsigned COUNT_WIDTH_MAX = 32;

	// duty scaling: low = period * duty / 1000 = ((period * duty) >> 3) / 125
	localparam int unsigned PROD_W      = PERIOD_W + DUTY_W;
	localparam int unsigned EIGHTH_W    = PROD_W - 3;
	localparam int unsigned RECIP_W     = 31;
	localparam int unsigned RECIP_SHIFT = 37;
	localparam int unsigned RPROD_W     = EIGHTH_W + RECIP_W;
	localparam int unsigned QUOT_W      = RPROD_W - RECIP_SHIFT;
	// ceil(2^37 / 125), exact for every dividend below 2^30
	localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_TIME_MS = 2'd2;

	// configuration reset values
	localparam logic [TPM_W-1:0]    TICKS_PER_MS_RST  = 20'd80000;
	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 23'd256000;
	localparam logic [DIGIT_W-1:0]  DIGIT_TIME_MS_RST = 13'd4000;

	// sequence delays in ms
	localparam logic [SEQ_MS_W-1:0] SEQ_START_MS = 13'd100;
	localparam logic [SEQ_MS_W-1:0] SEQ_SHORT_MS = 13'd200;
	localparam logic [SEQ_MS_W-1:0] SEQ_LONG_MS  = 13'd400;
	localparam logic [BTN_MS_W-1:0] BTN_HOLD_MS  = 8'd200;

	// display sequence steps
	localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_RLY_HI_A = 4'd1;
	localparam logic [STEP_W-1:0] STEP_RLY_LO_A = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RLY_HI_B = 4'd3;
	localparam logic [STEP_W-1:0] STEP_RLY_LO_B = 4'd4;
	localparam logic [STEP_W-1:0] STEP_DIGIT_0  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_DIGIT_1  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_DIGIT_2  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_DIGIT_3  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_END_HI   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_END_LO   = 4'd10;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_SHOW   = 2'd1,
		OP_DUTY   = 2'd2,
		OP_BUTTON = 2'd3
	} op_t;

	// command beat as seen by the control core
	typedef struct packed {
		op_t             op;
		logic [IP_W-1:0] ip;
		logic            duty_zero;
	} item_t;

	// result levels
	typedef struct packed {
		logic relay;
		logic indicator;
		logic pwm_running;
		logic seq_active;
	} status_t;

endpackage

### hdl/pps_duty_scale.sv
// ----------------------------------------------------------------------------
// pps_duty_scale
// Two-stage scaler: low = period*duty/1000, high = period - low, both
// truncated to the counter width.
// ----------------------------------------------------------------------------
module pps_duty_scale #(
	parameter int unsigned COUNT_WIDTH = pps_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en_s2,
	input  logic                          en_s3,
	input  logic [pps_pkg::PERIOD_W-1:0]  period,
	input  logic [pps_pkg::DUTY_W-1:0]    duty,
	output logic [COUNT_WIDTH-1:0]        low_ticks,
	output logic [COUNT_WIDTH-1:0]        high_ticks
);
	import pps_pkg::*;

	logic [PROD_W-1:0]          prod;
	logic [EIGHTH_W-1:0]        eighth_s2;
	logic [RPROD_W-1:0]         rprod;
	logic [QUOT_W-1:0]          quot;
	logic [COUNT_WIDTH_MAX-1:0] low_full;
	logic [COUNT_WIDTH_MAX-1:0] high_full;
	logic [COUNT_WIDTH-1:0]     low_s3;
	logic [COUNT_WIDTH-1:0]     high_s3;

	assign prod = PROD_W'(period) * PROD_W'(duty);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			eighth_s2 <= prod[PROD_W-1:3];
		end
	end

	// divide by 125 through the reciprocal
	assign rprod     = RPROD_W'(eighth_s2) * RPROD_W'(RECIP_125);
	assign quot      = rprod[RECIP_SHIFT +: QUOT_W];
	assign low_full  = COUNT_WIDTH_MAX'(quot);
	assign high_full = COUNT_WIDTH_MAX'(period) - low_full;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			low_s3  <= low_full[COUNT_WIDTH-1:0];
			high_s3 <= high_full[COUNT_WIDTH-1:0];
		end
	end

	assign low_ticks  = low_s3;
	assign high_ticks = high_s3;

endmodule

### hdl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Block state and its combinational update, registered on each committed
// beat: PWM counter, ms prescaler, display sequencer and button timer.
// ----------------------------------------------------------------------------
`include "pulse_and_pwm_byte_signaller_top_defines.svh"

module pps_ctrl #(
	parameter int unsigned COUNT_WIDTH = pps_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        commit,
	input  pps_pkg::item_t                              item,
	input  logic [COUNT_WIDTH-1:0]                      item_low,
	input  logic [COUNT_WIDTH-1:0]                      item_high,
	input  logic [pps_pkg::NUM_BYTES-1:0][COUNT_WIDTH-1:0] lane_low,
	input  logic [pps_pkg::NUM_BYTES-1:0][COUNT_WIDTH-1:0] lane_high,
	input  logic [pps_pkg::TPM_W-1:0]                   ticks_per_ms,
	input  logic [pps_pkg::DIGIT_W-1:0]                 digit_time_ms,
	output logic [pps_pkg::IP_W-1:0]                    shown_value,
	output pps_pkg::status_t                            status
);
	import pps_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic [STEP_W-1:0]      step_q, step_d, step_inc, lane_off;
	logic                   seq_armed_q, seq_armed_d;
	logic [SEQ_MS_W-1:0]    seq_ms_q, seq_ms_d;
	logic [TPM_W-1:0]       pre_q, pre_d;
	logic [IP_W-1:0]        shown_q, shown_d;
	logic                   pwm_en_q, pwm_en_d;
	logic                   phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [COUNT_WIDTH-1:0] low_q, low_d;
	logic [COUNT_WIDTH-1:0] high_q, high_d;
	logic                   relay_q, relay_d;
	logic                   ind_q, ind_d;
	logic [BTN_MS_W-1:0]    btn_ms_q, btn_ms_d;
	logic                   btn_armed_q, btn_armed_d;

	logic                   strobe;
	logic [1:0]             lane_idx;
	logic [BYTE_W-1:0]      lane_byte;

	assign strobe    = ({1'b0, pre_q} + (TPM_W+1)'(1)) >= {1'b0, ticks_per_ms};
	assign step_inc  = step_q + STEP_W'(1);
	assign lane_off  = step_inc - STEP_DIGIT_0;
	assign lane_idx  = lane_off[1:0];
	assign lane_byte = shown_q[{lane_idx, 3'b000} +: BYTE_W];

	always_comb begin
		step_d      = step_q;
		seq_armed_d = seq_armed_q;
		seq_ms_d    = seq_ms_q;
		pre_d       = pre_q;
		shown_d     = shown_q;
		pwm_en_d    = pwm_en_q;
		phase_d     = phase_q;
		count_d     = count_q;
		low_d       = low_q;
		high_d      = high_q;
		relay_d     = relay_q;
		ind_d       = ind_q;
		btn_ms_d    = btn_ms_q;
		btn_armed_d = btn_armed_q;
		unique case (item.op)
			OP_TICK: begin
				// PWM first
				if (pwm_en_q) begin
					if (count_q <= CNT_ONE) begin
						count_d = phase_q ? low_q : high_q;
						ind_d   = !phase_q;
						phase_d = !phase_q;
					end else begin
						count_d = count_q - CNT_ONE;
					end
				end
				if (strobe) begin
					pre_d = '0;
					// display sequence
					if (seq_armed_q) begin
						if (seq_ms_q <= SEQ_MS_W'(1)) begin
							seq_armed_d = 1'b0;
							step_d      = step_inc;
							unique case (step_inc)
								STEP_RLY_HI_A, STEP_RLY_HI_B: begin
									relay_d     = 1'b1;
									seq_armed_d = 1'b1;
									seq_ms_d    = SEQ_SHORT_MS;
								end
								STEP_RLY_LO_A: begin
									relay_d     = 1'b0;
									seq_armed_d = 1'b1;
									seq_ms_d    = SEQ_LONG_MS;
								end
								STEP_RLY_LO_B: begin
									relay_d     = 1'b0;
									seq_armed_d = 1'b1;
									seq_ms_d    = SEQ_SHORT_MS;
								end
								STEP_DIGIT_0, STEP_DIGIT_1, STEP_DIGIT_2, STEP_DIGIT_3: begin
									if (lane_byte == '0) begin
										pwm_en_d = 1'b0;
									end else begin
										low_d    = lane_low[lane_idx];
										high_d   = lane_high[lane_idx];
										count_d  = lane_low[lane_idx];
										pwm_en_d = 1'b1;
									end
									seq_armed_d = 1'b1;
									seq_ms_d    = digit_time_ms;
								end
								STEP_END_HI: begin
									pwm_en_d    = 1'b0;
									relay_d     = 1'b1;
									seq_armed_d = 1'b1;
									seq_ms_d    = SEQ_SHORT_MS;
								end
								STEP_END_LO: begin
									relay_d = 1'b0;
									step_d  = STEP_IDLE;
								end
								default: begin
								end
							endcase
						end else begin
							seq_ms_d = seq_ms_q - SEQ_MS_W'(1);
						end
					end
					// button timer last, its release wins over the sequence
					if (btn_armed_q) begin
						if (btn_ms_q <= BTN_MS_W'(1)) begin
							btn_armed_d = 1'b0;
							btn_ms_d    = '0;
							relay_d     = 1'b0;
						end else begin
							btn_ms_d = btn_ms_q - BTN_MS_W'(1);
						end
					end
				end else begin
					pre_d = pre_q + TPM_W'(1);
				end
			end
			OP_SHOW: begin
				shown_d     = item.ip;
				seq_armed_d = 1'b1;
				seq_ms_d    = SEQ_START_MS;
			end
			OP_DUTY: begin
				if (item.duty_zero) begin
					pwm_en_d = 1'b0;
				end else begin
					low_d    = item_low;
					high_d   = item_high;
					count_d  = item_low;
					pwm_en_d = 1'b1;
				end
			end
			OP_BUTTON: begin
				relay_d     = 1'b1;
				btn_armed_d = 1'b1;
				btn_ms_d    = BTN_HOLD_MS;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			seq_armed_q <= 1'b0;
			seq_ms_q    <= '0;
			pre_q       <= '0;
			shown_q     <= '0;
			pwm_en_q    <= 1'b0;
			phase_q     <= 1'b0;
			count_q     <= '0;
			low_q       <= '0;
			high_q      <= '0;
			relay_q     <= 1'b0;
			ind_q       <= 1'b0;
			btn_ms_q    <= '0;
			btn_armed_q <= 1'b0;
		end else if (commit) begin
			step_q      <= step_d;
			seq_armed_q <= seq_armed_d;
			seq_ms_q    <= seq_ms_d;
			pre_q       <= pre_d;
			shown_q     <= shown_d;
			pwm_en_q    <= pwm_en_d;
			phase_q     <= phase_d;
			count_q     <= count_d;
			low_q       <= low_d;
			high_q      <= high_d;
			relay_q     <= relay_d;
			ind_q       <= ind_d;
			btn_ms_q    <= btn_ms_d;
			btn_armed_q <= btn_armed_d;
		end
	end

	assign shown_value        = shown_q;
	assign status.relay       = relay_q;
	assign status.indicator   = ind_q;
	assign status.pwm_running = pwm_en_q;
	assign status.seq_active  = seq_armed_q;

	// the step wraps back to idle right after the final relay release
	`PPS_ASSERT_IMP(a_step_range, 1'b1, step_q <= STEP_END_HI)
	// an armed button timer always has time left
	`PPS_ASSERT_IMP(a_btn_time, btn_armed_q, btn_ms_q != '0)
	// the indicator only moves on a PWM reload
	`PPS_ASSERT_NXT(a_ind_hold, !pwm_en_q, $stable(ind_q))
	// result levels only change on a committed beat
	`PPS_ASSERT_NXT(a_hold_no_commit, !commit,
		$stable({relay_q, ind_q, pwm_en_q, seq_armed_q}))

endmodule

### hdl/pulse_and_pwm_byte_signaller_top.sv
// ----------------------------------------------------------------------------
// pulse_and_pwm_byte_signaller_top
// Tick-driven relay pulser, PWM indicator and byte display sequencer.
// ----------------------------------------------------------------------------
// Every input beat is either one timer tick or a command (show address, set
// duty, press button) and returns one result beat with the relay and
// indicator levels and the PWM and sequence flags after that beat. The block
// takes one beat per clock while the result is not stalled and passes each
// beat through four registers: an input register, a multiply stage and a
// divide-by-1000 reciprocal stage for the set-duty value, then the state
// update, whose registers double as the result register. The state update
// closes its loop through its own registers, so beats stream back to back;
// a stalled result only holds back the stages behind it, and empty stages
// still take new beats. The duties for the four bytes of the shown address
// are scaled in four free-running lanes from the stored address and the PWM
// period; they settle through the multiply and divide registers after either
// changes. Configuration writes take effect on the next cycle and are
// expected only when no beat is in flight. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module pulse_and_pwm_byte_signaller_top #(
	parameter int unsigned COUNT_WIDTH = pps_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write_en,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
	// input beats
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [pps_pkg::OP_W-1:0]       operation,
	input  logic [pps_pkg::IP_W-1:0]       ip_address,
	input  logic [pps_pkg::DUTY_W-1:0]     duty,
	// result beats
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           relay_level,
	output logic                           indicator_level,
	output logic                           pwm_running,
	output logic                           sequence_active
);
	import pps_pkg::*;

	// configuration registers
	logic [TPM_W-1:0]    ticks_per_ms_q;
	logic [PERIOD_W-1:0] pwm_period_q;
	logic [DIGIT_W-1:0]  digit_time_ms_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, out_free, commit;

	// pipeline payload
	op_t               op_s1, op_s2, op_s3;
	logic [IP_W-1:0]   ip_s1, ip_s2, ip_s3;
	logic [DUTY_W-1:0] duty_s1;
	logic              dzero_s2, dzero_s3;

	item_t                                item;
	status_t                              status;
	logic [COUNT_WIDTH-1:0]               item_low, item_high;
	logic [NUM_BYTES-1:0][COUNT_WIDTH-1:0] lane_low, lane_high;
	logic [IP_W-1:0]                      shown_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_ms_q  <= TICKS_PER_MS_RST;
			pwm_period_q    <= PWM_PERIOD_RST;
			digit_time_ms_q <= DIGIT_TIME_MS_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_TICKS_PER_MS:  ticks_per_ms_q  <= cfg_data[TPM_W-1:0];
				CFG_PWM_PERIOD:    pwm_period_q    <= cfg_data[PERIOD_W-1:0];
				CFG_DIGIT_TIME_MS: digit_time_ms_q <= cfg_data[DIGIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on
	assign out_free   = !out_valid_q || result_ready;
	assign commit     = v_s3 && out_free;
	assign rdy_s3     = !v_s3 || out_free;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= item_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1   <= op_t'(operation);
			ip_s1   <= ip_address;
			duty_s1 <= duty;
		end
		if (rdy_s2) begin
			op_s2    <= op_s1;
			ip_s2    <= ip_s1;
			dzero_s2 <= (duty_s1 == '0);
		end
		if (rdy_s3) begin
			op_s3    <= op_s2;
			ip_s3    <= ip_s2;
			dzero_s3 <= dzero_s2;
		end
	end

	// set-duty lane, moves in step with the beat
	pps_duty_scale #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_item_scale (
		.clk        (clk),
		.en_s2      (rdy_s2),
		.en_s3      (rdy_s3),
		.period     (pwm_period_q),
		.duty       (duty_s1),
		.low_ticks  (item_low),
		.high_ticks (item_high)
	);

	// byte lanes for the display sequence, free running
	for (genvar i = 0; i < NUM_BYTES; i++) begin : g_lane
		pps_duty_scale #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane_scale (
			.clk        (clk),
			.en_s2      (1'b1),
			.en_s3      (1'b1),
			.period     (pwm_period_q),
			.duty       (DUTY_W'(shown_value[i*BYTE_W +: BYTE_W])),
			.low_ticks  (lane_low[i]),
			.high_ticks (lane_high[i])
		);
	end

	assign item.op        = op_s3;
	assign item.ip        = ip_s3;
	assign item.duty_zero = dzero_s3;

	pps_ctrl #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.commit        (commit),
		.item          (item),
		.item_low      (item_low),
		.item_high     (item_high),
		.lane_low      (lane_low),
		.lane_high     (lane_high),
		.ticks_per_ms  (ticks_per_ms_q),
		.digit_time_ms (digit_time_ms_q),
		.shown_value   (shown_value),
		.status        (status)
	);

	assign result_valid    = out_valid_q;
	assign relay_level     = status.relay;
	assign indicator_level = status.indicator;
	assign pwm_running     = status.pwm_running;
	assign sequence_active = status.seq_active;

endmodule
